### hdl/lzwc_pkg.sv
package lzwc_pkg;

    localparam int BYTE_W        = 8;
    localparam int OUT_CODE_W    = 16;
    localparam int FIRST_LEARNED = 256;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_stream;
    } sym_t;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] out_code;
        logic                  last_code;
    } code_t;

endpackage

### hdl/lzwc_dict.sv
module lzwc_dict #(
    parameter int DICT_ENTRIES = 4096
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               rd_en,
    input  logic [$clog2(DICT_ENTRIES)-1:0]                    rd_addr,
    input  logic                                               wr_en,
    input  logic [$clog2(DICT_ENTRIES)-1:0]                    wr_addr,
    input  logic [$clog2(DICT_ENTRIES)+lzwc_pkg::BYTE_W-1:0]   pair,
    output logic                                               hit
);

    localparam int CodeW  = $clog2(DICT_ENTRIES);
    localparam int EntryW = CodeW + lzwc_pkg::BYTE_W;

    logic [EntryW-1:0] mem [DICT_ENTRIES];
    logic [EntryW-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= pair;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // marks that rd_data_reg holds data from an entry read in the previous cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    // shared pair comparator
    assign hit = rd_valid_reg && (rd_data_reg == pair);

endmodule

### hdl/lzwc_out_fifo.sv
module lzwc_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lzwc_pkg::code_t push_data,
    output logic            full,
    output logic            code_valid,
    input  logic            code_stall,
    output lzwc_pkg::code_t code_word
);

    lzwc_pkg::code_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            pop;

    assign code_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign code_word  = slot_reg[rd_ptr_reg];
    assign pop        = code_valid && !code_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/lzw_byte_compressor.sv
// LZW byte compressor. One raw byte is taken per sym transaction and up to two
// 16-bit code words come out on the code channel, the final one of a stream
// flagged by last_code after the byte marked end_of_stream. Learned
// (prefix, byte) pairs live in a dictionary RAM of DICT_ENTRIES words with separate
// read and write ports and are matched by one comparator walking the learned
// entries one per cycle until a hit or the next free code; the first byte of a
// stream is taken without a search. sym_stall stays high for the whole search.
// Emitted codes sit in a two-deep output queue, so a new byte is taken while
// earlier codes still wait downstream.
module lzw_byte_compressor #(
    parameter int DICT_ENTRIES = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sym_valid,
    output logic            sym_stall,
    input  lzwc_pkg::sym_t  sym,
    output logic            code_valid,
    input  logic            code_stall,
    output lzwc_pkg::code_t code_word
);

    localparam int CodeW = $clog2(DICT_ENTRIES);
    localparam int NfcW  = $clog2(DICT_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_FLUSH  = 4'b1000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [lzwc_pkg::BYTE_W-1:0]   byte_reg;
    logic [lzwc_pkg::BYTE_W-1:0]   byte_next;
    logic                          eos_reg;
    logic                          eos_next;
    logic [CodeW-1:0]              prefix_reg;
    logic [CodeW-1:0]              prefix_next;
    logic                          pvalid_reg;
    logic                          pvalid_next;
    logic [NfcW-1:0]               nfc_reg;
    logic [NfcW-1:0]               nfc_next;
    logic [NfcW-1:0]               issue_reg;
    logic [NfcW-1:0]               issue_next;
    logic [NfcW-1:0]               hit_addr_reg;
    logic [NfcW-1:0]               hit_addr_next;

    logic                          rd_en;
    logic                          wr_en;
    logic                          hit;
    logic                          push;
    lzwc_pkg::code_t               push_data;
    logic                          fifo_full;

    localparam logic [NfcW-1:0] FirstCode = NfcW'(lzwc_pkg::FIRST_LEARNED);
    localparam logic [NfcW-1:0] DictLimit = NfcW'(DICT_ENTRIES);

    assign sym_stall = (state_reg != ST_IDLE);

    lzwc_dict #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_dict (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[CodeW-1:0]),
        .wr_en   (wr_en),
        .wr_addr (nfc_reg[CodeW-1:0]),
        .pair    ({prefix_reg, byte_reg}),
        .hit     (hit)
    );

    lzwc_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (fifo_full),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_word  (code_word)
    );

    always_comb
    begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        eos_next      = eos_reg;
        prefix_next   = prefix_reg;
        pvalid_next   = pvalid_reg;
        nfc_next      = nfc_reg;
        issue_next    = issue_reg;
        hit_addr_next = hit_addr_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        push          = 1'b0;
        push_data     = '{out_code: lzwc_pkg::OUT_CODE_W'(prefix_reg), last_code: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (sym_valid)
                begin
                    byte_next = sym.in_byte;
                    eos_next  = sym.end_of_stream;
                    if (!pvalid_reg)
                    begin
                        prefix_next = CodeW'(sym.in_byte);
                        pvalid_next = 1'b1;
                        state_next  = sym.end_of_stream ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        issue_next = FirstCode;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    prefix_next = hit_addr_reg[CodeW-1:0];
                    state_next  = eos_reg ? ST_FLUSH : ST_IDLE;
                end
                else if (issue_reg < nfc_reg)
                begin
                    rd_en         = 1'b1;
                    hit_addr_next = issue_reg;
                    issue_next    = issue_reg + NfcW'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!fifo_full)
                begin
                    push = 1'b1;
                    if (nfc_reg < DictLimit)
                    begin
                        wr_en    = 1'b1;
                        nfc_next = nfc_reg + NfcW'(1);
                    end
                    prefix_next = CodeW'(byte_reg);
                    state_next  = eos_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                push_data = '{out_code: lzwc_pkg::OUT_CODE_W'(prefix_reg), last_code: 1'b1};
                if (!fifo_full)
                begin
                    push        = 1'b1;
                    prefix_next = '0;
                    pvalid_next = 1'b0;
                    nfc_next    = FirstCode;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        eos_reg      <= eos_next;
        issue_reg    <= issue_next;
        hit_addr_reg <= hit_addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            prefix_reg <= '0;
            pvalid_reg <= 1'b0;
            nfc_reg    <= FirstCode;
        end
        else
        begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            pvalid_reg <= pvalid_next;
            nfc_reg    <= nfc_next;
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DICT_SIZE = 4096;

    logic            clk;
    logic            rst_n;
    logic            sym_valid;
    logic            sym_stall;
    lzwc_pkg::sym_t  sym;
    logic            code_valid;
    logic            code_stall;
    lzwc_pkg::code_t code_word;

    lzw_byte_compressor #(
        .DICT_ENTRIES(DICT_SIZE)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym        (sym),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_word  (code_word)
    );

    // compressor state as seen from outside
    logic [15:0] learned_prefix [DICT_SIZE];
    logic [7:0]  learned_byte [DICT_SIZE];
    int unsigned free_code;
    logic [15:0] prefix_code;
    bit          have_prefix;

    lzwc_pkg::code_t pending_codes [$];
    int              errors;
    bit              idle_en;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic push_code(input logic [15:0] c, input logic last);
        lzwc_pkg::code_t w;
        w.out_code  = c;
        w.last_code = last;
        pending_codes.push_back(w);
    endtask

    task automatic compress_byte(input lzwc_pkg::sym_t s);
        int unsigned hit;
        bit          found;
        found = 1'b0;
        hit   = 0;
        if (!have_prefix)
        begin
            prefix_code = {8'h00, s.in_byte};
            have_prefix = 1'b1;
        end
        else
        begin
            for (int unsigned i = lzwc_pkg::FIRST_LEARNED; i < free_code; i++)
            begin
                if (!found && learned_prefix[i] == prefix_code && learned_byte[i] == s.in_byte)
                begin
                    found = 1'b1;
                    hit   = i;
                end
            end
            if (found)
            begin
                prefix_code = hit[15:0];
            end
            else
            begin
                if (free_code < DICT_SIZE)
                begin
                    learned_prefix[free_code] = prefix_code;
                    learned_byte[free_code]   = s.in_byte;
                    free_code++;
                end
                push_code(prefix_code, 1'b0);
                prefix_code = {8'h00, s.in_byte};
            end
        end
        if (s.end_of_stream)
        begin
            push_code(prefix_code, 1'b1);
            prefix_code = '0;
            have_prefix = 1'b0;
            free_code   = lzwc_pkg::FIRST_LEARNED;
        end
    endtask

    task automatic send_sym(input logic [7:0] b, input logic eos);
        lzwc_pkg::sym_t s;
        s.in_byte       = b;
        s.end_of_stream = eos;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            sym_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        sym_valid <= 1'b1;
        sym       <= s;
        do
            @(posedge clk);
        while (sym_stall);
        compress_byte(s);
    endtask

    task automatic drain_codes();
        sym_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_codes.size() != 0);
    endtask

    task automatic send_stream(input int len, input bit narrow);
        logic [7:0] alphabet [3];
        logic [7:0] b;
        foreach (alphabet[k])
            alphabet[k] = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            b = narrow ? alphabet[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
            send_sym(b, i == len - 1);
        end
    endtask

    task automatic test_directed();
        logic [7:0] misses [4];
        misses = '{8'h80, 8'h7F, 8'h55, 8'hAA};
        // one-byte stream: only the flush
        send_sym(8'hFF, 1'b1);
        // run of zeros builds a chain of learned codes, ends on a hit
        for (int i = 0; i < 6; i++)
            send_sym(8'h00, i == 5);
        // alternating pattern
        for (int i = 0; i < 7; i++)
            send_sym((i % 2) ? 8'h42 : 8'h41, i == 6);
        // all misses, end on a miss gives two codes
        foreach (misses[i])
            send_sym(misses[i], i == 3);
        drain_codes();
    endtask

    task automatic test_random_streams();
        int sent;
        int len;
        sent = 0;
        while (sent < 100)
        begin
            len = $urandom_range(1, 20);
            send_stream(len, $urandom_range(0, 3) != 0);
            sent += len;
            if ($urandom_range(0, 5) == 0)
                drain_codes();
        end
        drain_codes();
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        for (int i = 0; i < 4; i++)
            send_stream($urandom_range(1, 12), (i % 2) != 0);
        drain_codes();
    endtask

    always @(posedge clk)
    begin
        lzwc_pkg::code_t want;
        if (rst_n && code_valid && !code_stall)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected code word, expected none, actual code=%0d last=%0b",
                         $time, code_word.out_code, code_word.last_code);
                errors++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (code_word.out_code !== want.out_code)
                begin
                    $display("%0t: out_code mismatch, expected %0d, actual %0d",
                             $time, want.out_code, code_word.out_code);
                    errors++;
                end
                if (code_word.last_code !== want.last_code)
                begin
                    $display("%0t: last_code mismatch, expected %0b, actual %0b",
                             $time, want.last_code, code_word.last_code);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        code_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                code_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                code_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        errors      = 0;
        idle_en     = 1'b1;
        free_code   = lzwc_pkg::FIRST_LEARNED;
        prefix_code = '0;
        have_prefix = 1'b0;
        clk         = 1'b0;
        rst_n       = 1'b0;
        sym_valid   <= 1'b0;
        sym         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_streams();
        test_back_to_back();

        repeat (DICT_SIZE) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/lzwc_pkg.sv
hdl/lzwc_dict.sv
hdl/lzwc_out_fifo.sv
hdl/lzw_byte_compressor.sv
verif/tb.sv
